@@ design/goldbach_pair_finder_assert.svh @@
// assertion macros shared by the goldbach pair finder checker
`ifndef GOLDBACH_PAIR_FINDER_ASSERT_SVH
`define GOLDBACH_PAIR_FINDER_ASSERT_SVH

// same-cycle implication
`define GPF_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("goldbach pair finder check failed");

// next-cycle implication
`define GPF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("goldbach pair finder check failed");

`endif

@@ design/gpf_pkg.sv @@
// shared constants for the goldbach pair finder
package gpf_pkg;

  localparam int LIMIT_DEFAULT = 65535;
  localparam int MAP_MAX       = 65535;

  localparam int NUM_W   = 16;
  localparam int IN_W    = 16;
  localparam int OUT_W   = 40;

  localparam logic [NUM_W-1:0] FIRST_CAND = 16'd3;
  localparam logic [NUM_W-1:0] CAND_STEP  = 16'd2;
  localparam logic [NUM_W-1:0] MAP_LAST   = 16'hFFFF;
  localparam logic [8:0]       FIRST_BASE = 9'd2;

endpackage

@@ design/goldbach_pair_finder.sv @@
// goldbach pair finder: sieve-built prime map and one-candidate-per-cycle search
//
//  channel | dir | tdata fields (low bit up)                        | tuser
//  s_axis  | in  | number[15:0]                                     | none
//  m_axis  | out | found[0], first_prime[16:1], second_prime[32:17]  | none
//
//  first item after reset: the whole map is filled, then each sieve base k whose square
//  is within the sieve top is read and, if prime, its multiples from k*k are cleared
//  each query: accepted in S_IDLE, one odd candidate tried per cycle, then S_HOLD
//  the map has one write port and two read ports with registered read data
//  rst clears control and map_ready; the map is rebuilt on the next item
//  a result waits in the output register while the next item is accepted
module goldbach_pair_finder #(
  parameter int LIMIT = gpf_pkg::LIMIT_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [gpf_pkg::IN_W-1:0]   s_tdata,   // number[15:0]
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [gpf_pkg::OUT_W-1:0]  m_tdata    // found, first_prime, second_prime, pad
);

  localparam logic [15:0] SIEVE_TOP =
    (LIMIT > gpf_pkg::MAP_MAX) ? gpf_pkg::MAP_LAST : 16'(LIMIT);

  typedef enum logic [2:0] {
    S_IDLE, S_FILL, S_SQ, S_PRD, S_PCHK, S_CLR, S_QRUN, S_HOLD
  } state_t;

  state_t      state;
  logic        map_ready;
  logic [15:0] cnt;
  logic [8:0]  k;
  logic [16:0] sq;
  logic [16:0] m;
  logic [15:0] n;
  logic [14:0] half;
  logic [15:0] i;
  logic [15:0] cand;
  logic        pend;
  logic        res_found;
  logic [15:0] res_a;
  logic [15:0] res_b;

  logic        prime_map [0:65535];
  logic        rd_a;
  logic        rd_b;
  logic [15:0] addr_a;
  logic [15:0] addr_b;
  logic        we;
  logic [15:0] waddr;
  logic        wdata;
  logic [16:0] ksq;
  logic        clr_ok;

  assign s_tready = (state == S_IDLE);
  assign ksq      = {8'd0, k} * {8'd0, k};
  assign clr_ok   = (m <= {1'b0, SIEVE_TOP});
  assign addr_a   = (state == S_PRD) ? {7'd0, k} : i;
  assign addr_b   = n - i;

  always_comb begin
    we    = 1'b0;
    waddr = cnt;
    wdata = 1'b0;
    unique case (state)
      S_FILL: begin
        we    = 1'b1;
        wdata = (cnt >= 16'd2) && (cnt <= SIEVE_TOP);
      end
      S_CLR: begin
        we    = clr_ok;
        waddr = m[15:0];
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      prime_map[waddr] <= wdata;
    end
    rd_a <= prime_map[addr_a];
    rd_b <= prime_map[addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      map_ready <= 1'b0;
      m_tvalid  <= 1'b0;
      pend      <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_HOLD)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            n     <= s_tdata;
            half  <= s_tdata[15:1];
            i     <= gpf_pkg::FIRST_CAND;
            pend  <= 1'b0;
            cnt   <= '0;
            state <= map_ready ? S_QRUN : S_FILL;
          end
        end
        S_FILL: begin
          cnt <= cnt + 16'd1;
          if (cnt == gpf_pkg::MAP_LAST) begin
            k     <= gpf_pkg::FIRST_BASE;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          sq    <= ksq;
          state <= S_PRD;
        end
        S_PRD: begin
          if (sq > {1'b0, SIEVE_TOP}) begin
            map_ready <= 1'b1;
            state     <= S_QRUN;
          end else begin
            state <= S_PCHK;
          end
        end
        S_PCHK: begin
          if (rd_a) begin
            m     <= sq;
            state <= S_CLR;
          end else begin
            k     <= k + 9'd1;
            state <= S_SQ;
          end
        end
        S_CLR: begin
          if (clr_ok) begin
            m <= m + {8'd0, k};
          end else begin
            k     <= k + 9'd1;
            state <= S_SQ;
          end
        end
        S_QRUN: begin
          if (pend && rd_a && rd_b) begin
            res_found <= 1'b1;
            res_a     <= cand;
            res_b     <= n - cand;
            pend      <= 1'b0;
            state     <= S_HOLD;
          end else if (i > {1'b0, half}) begin
            res_found <= 1'b0;
            res_a     <= '0;
            res_b     <= '0;
            pend      <= 1'b0;
            state     <= S_HOLD;
          end else begin
            pend <= 1'b1;
            cand <= i;
            i    <= i + gpf_pkg::CAND_STEP;
          end
        end
        S_HOLD: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {7'd0, res_b, res_a, res_found};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ design/gpf_checker.sv @@
// port-level checker for the goldbach pair finder, with its bind
`include "goldbach_pair_finder_assert.svh"

module gpf_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [gpf_pkg::OUT_W-1:0]  m_tdata
);

  logic        found;
  logic [15:0] first_p;
  logic [15:0] second_p;
  logic        hit_ok;

  assign found    = m_tdata[0];
  assign first_p  = m_tdata[16:1];
  assign second_p = m_tdata[32:17];
  assign hit_ok   = first_p[0] && (first_p >= gpf_pkg::FIRST_CAND) && (first_p <= second_p);

  `GPF_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `GPF_ASSERT_NEXT(a_busy_after_in, clk, rst, s_tvalid && s_tready, !s_tready)
  `GPF_ASSERT_NOW(a_miss_zero, clk, rst, m_tvalid && !found, first_p == 16'd0 && second_p == 16'd0)
  `GPF_ASSERT_NOW(a_hit_order, clk, rst, m_tvalid && found, hit_ok)

endmodule

bind goldbach_pair_finder gpf_checker u_gpf_checker (.*);

@@ verif/goldbach_pair_finder_test.sv @@
// testbench for the goldbach pair finder: directed and random queries checked against a local sieve
`timescale 1ns / 1ps

module goldbach_pair_finder_test;

  typedef struct packed {
    logic                      found;
    logic [gpf_pkg::NUM_W-1:0] first_prime;
    logic [gpf_pkg::NUM_W-1:0] second_prime;
  } goldbach_pair_t;

  typedef enum int {
    RX_ALWAYS,
    RX_HALF,
    RX_SPARSE,
    RX_ALTERNATE
  } rx_mode_t;

  localparam int HOLD_CYCLES = 3000;
  localparam int DRAIN_CYCLES = 200;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [gpf_pkg::IN_W-1:0]  s_tdata = '0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [gpf_pkg::OUT_W-1:0] m_tdata;

  bit             is_prime [0:65535];
  goldbach_pair_t expected_pairs [$];
  goldbach_pair_t want;
  goldbach_pair_t got;
  int             error_count = 0;
  int             burst_left = 0;
  int             hold_request = 0;
  int             hold_served = 0;
  int             hold_left = 0;
  rx_mode_t       rx_mode = RX_ALWAYS;
  int             rx_left = 0;

  goldbach_pair_finder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic build_prime_table();
    int unsigned k;
    int unsigned m;
    for (k = 0; k < 65536; k++) begin
      is_prime[16'(k)] = 1'b1;
    end
    is_prime[16'd0] = 1'b0;
    is_prime[16'd1] = 1'b0;
    for (k = 2; k * k <= 65535; k++) begin
      if (is_prime[16'(k)]) begin
        for (m = k * k; m <= 65535; m += k) begin
          is_prime[16'(m)] = 1'b0;
        end
      end
    end
  endtask

  function automatic goldbach_pair_t predict_pair(input logic [gpf_pkg::NUM_W-1:0] n);
    goldbach_pair_t r;
    int unsigned    half;
    int unsigned    i;
    r = '0;
    half = n / 2;
    for (i = 3; i <= half; i += 2) begin
      if (is_prime[16'(i)] && is_prime[16'(n - i)]) begin
        r.found = 1'b1;
        r.first_prime = i[gpf_pkg::NUM_W-1:0];
        r.second_prime = n - i[gpf_pkg::NUM_W-1:0];
        break;
      end
    end
    return r;
  endfunction

  // one input transfer, with bursts and gaps
  task automatic send_number(input logic [gpf_pkg::NUM_W-1:0] n);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 9);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= n;
    do @(posedge clk); while (!s_tready);
    expected_pairs.push_back(predict_pair(n));
  endtask

  // receiver stall pattern plus long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_served != hold_request) begin
      hold_served = hold_request;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(100, 400);
      end
      rx_left--;
      case (rx_mode)
        RX_ALWAYS: m_tready <= 1'b1;
        RX_HALF: m_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= ~m_tready;
      endcase
    end
  end

  // result check on each output transfer
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got.found = m_tdata[0];
      got.first_prime = m_tdata[16:1];
      got.second_prime = m_tdata[32:17];
      if (expected_pairs.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d %0d %0d",
                 $time, got.found, got.first_prime, got.second_prime);
        error_count++;
      end else begin
        want = expected_pairs.pop_front();
        if (got.found !== want.found) begin
          $display("%0t: found mismatch, expected %0d, actual %0d",
                   $time, want.found, got.found);
          error_count++;
        end
        if (got.first_prime !== want.first_prime) begin
          $display("%0t: first_prime mismatch, expected %0d, actual %0d",
                   $time, want.first_prime, got.first_prime);
          error_count++;
        end
        if (got.second_prime !== want.second_prime) begin
          $display("%0t: second_prime mismatch, expected %0d, actual %0d",
                   $time, want.second_prime, got.second_prime);
          error_count++;
        end
      end
    end
  end

  task automatic test_small_numbers();
    int k;
    for (k = 0; k <= 9; k++) begin
      send_number(k[gpf_pkg::NUM_W-1:0]);
    end
    send_number(16'd12);
    send_number(16'd98);
    send_number(16'd100);
    send_number(16'd128);
  endtask

  task automatic test_extreme_numbers();
    send_number(16'd65534);
    send_number(16'd65532);
    send_number(16'd65535);
    send_number(16'd65533);
    send_number(16'hAAAA);
    send_number(16'h5554);
    send_number(16'h8000);
    send_number(16'h7FFE);
    send_number(16'd0);
    send_number(16'd6);
  endtask

  task automatic test_random_even(input int count);
    int k;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(0, 4) == 0)
        send_number(16'($urandom_range(3, 500) * 2));
      else
        send_number({15'($urandom_range(3, 32767)), 1'b0});
    end
  endtask

  // odd, tiny and random full-range queries; large odd ones are slow so kept rare
  task automatic test_irregular_numbers(input int count);
    int k;
    int pick;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60)
        send_number(16'($urandom_range(0, 511) * 2 + 1));
      else if (pick < 85)
        send_number(16'($urandom_range(0, 5)));
      else if (pick < 98)
        send_number(16'($urandom));
      else
        send_number(16'($urandom_range(32768, 65535)) | 16'd1);
    end
  endtask

  task automatic test_output_backpressure();
    int k;
    hold_request++;
    burst_left = 40;
    for (k = 0; k < 20; k++) begin
      send_number(16'($urandom_range(3, 200) * 2));
    end
  endtask

  initial begin
    build_prime_table();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_small_numbers();
    test_extreme_numbers();
    test_random_even(600);
    test_output_backpressure();
    test_irregular_numbers(200);
    test_random_even(500);
    @(posedge clk);
    s_tvalid <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("** goldbach_pair_finder: PASSED **");
    end else begin
      $display("** goldbach_pair_finder: FAILED **");
    end
    $finish;
  end

  initial begin
    #200000000;
    $display("** goldbach_pair_finder: FAILED **");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/gpf_pkg.sv
design/goldbach_pair_finder.sv
design/gpf_checker.sv
verif/goldbach_pair_finder_test.sv
